// ===== sv/prescaled_match_timer_assert.svh =====
// Assertion macros for the prescaled match timer.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef PRESCALED_MATCH_TIMER_ASSERT_SVH
`define PRESCALED_MATCH_TIMER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PMT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PMT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pmt_pkg.sv =====
// Shared types and constants of the prescaled match timer.
// Used by pmt_step and prescaled_match_timer; depends on nothing.
`default_nettype none

package pmt_pkg;

  localparam int unsigned CntW   = 32;
  localparam int unsigned PscW   = 32;
  localparam int unsigned BitsW  = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_LOAD  = 3'd3,
    OP_CLEAR = 3'd4
  } opcode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PRESCALE  = 3'd0,
    REG_MATCH     = 3'd1,
    REG_CNT_BITS  = 3'd2,
    REG_RST_MATCH = 3'd3,
    REG_IRQ_EN    = 3'd4
  } cfg_reg_e;

  localparam logic [PscW-1:0]  PrescaleReset = '0;
  localparam logic [CntW-1:0]  MatchReset    = '1;
  localparam logic [BitsW-1:0] CntBitsReset  = 6'd32;

  typedef struct packed {
    logic [PscW-1:0]  prescale_value;
    logic [CntW-1:0]  match_value;
    logic [BitsW-1:0] counter_bits;
    logic             reset_on_match;
    logic             interrupt_enable;
  } pmt_cfg_t;

  typedef struct packed {
    logic [CntW-1:0] main_count;
    logic [PscW-1:0] prescale_count;
    logic            enabled;
    logic            flag_pending;
    logic            toggle_out;
  } pmt_state_t;

endpackage

`default_nettype wire

// ===== sv/pmt_step.sv =====
// Next-state logic of the prescaled match timer for one operation.
// Depends on pmt_pkg for the opcode, configuration and state types.
`default_nettype none

module pmt_step import pmt_pkg::*; #(
  parameter int unsigned MaxCounterBits = 32
) (
  input  pmt_cfg_t        cfg_i,
  input  pmt_state_t      state_i,
  input  opcode_e         op_i,
  input  logic [CntW-1:0] load_value_i,
  output pmt_state_t      state_o
);

  localparam logic [BitsW-1:0] MaxBits = BitsW'(MaxCounterBits);

  logic [BitsW-1:0] bits_eff;
  logic [CntW-1:0]  mask;
  logic [CntW-1:0]  target;
  logic [CntW-1:0]  cur;
  logic [CntW-1:0]  step_count;
  logic             step_hit;

  // Active width is clamped into one to the synthesised maximum.
  always_comb begin
    if (cfg_i.counter_bits == '0) begin
      bits_eff = BitsW'(1);
    end else if (cfg_i.counter_bits > MaxBits) begin
      bits_eff = MaxBits;
    end else begin
      bits_eff = cfg_i.counter_bits;
    end
    for (int i = 0; i < CntW; i++) begin
      mask[i] = (BitsW'(i) < bits_eff);
    end
  end

  always_comb begin
    target = cfg_i.match_value & mask;
    cur    = state_i.main_count & mask;
    if (cfg_i.reset_on_match && (cur == target)) begin
      step_count = '0;
    end else begin
      step_count = (cur + CntW'(1)) & mask;
    end
    step_hit = (step_count == target);
  end

  always_comb begin
    state_o = state_i;
    case (op_i)
      OP_TICK: begin
        if (state_i.enabled) begin
          if (state_i.prescale_count >= cfg_i.prescale_value) begin
            state_o.prescale_count = '0;
            state_o.main_count     = step_count;
            if (step_hit) begin
              state_o.toggle_out = ~state_i.toggle_out;
              if (cfg_i.interrupt_enable) begin
                state_o.flag_pending = 1'b1;
              end
            end
          end else begin
            state_o.prescale_count = state_i.prescale_count + PscW'(1);
          end
        end
      end
      OP_START: begin
        state_o.flag_pending = 1'b0;
        state_o.toggle_out   = 1'b0;
        state_o.enabled      = 1'b1;
      end
      OP_STOP: begin
        state_o.enabled = 1'b0;
      end
      OP_LOAD: begin
        state_o.main_count     = load_value_i & mask;
        state_o.prescale_count = '0;
      end
      OP_CLEAR: begin
        state_o.flag_pending = 1'b0;
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/prescaled_match_timer.sv =====
// Top level of the prescaled match timer: request register, state and result.
// Depends on pmt_pkg, pmt_step and prescaled_match_timer_assert.svh.
`default_nettype none

`include "prescaled_match_timer_assert.svh"

// A general-purpose timer with a 32-bit prescaler and one match channel. Each
// request carries an operation (tick, start, stop, load count, clear flag) and
// yields exactly one result reporting the count, the pending interrupt flag,
// the match output level and the running state after that operation. While
// the output is not stalled, the block sustains one request per clock cycle:
// a request is captured in an input register, and from there the whole state
// update (prescale compare and increment, counter step with match compare) is
// done in one pass of logic and written into the state registers, which
// double as the result register; this happens once the result slot is empty
// or its current result is being taken by the receiver.
// While a result is waiting on a stalled output, one further request can be
// held in the input register; only when both are occupied is in_stall_o
// raised. Configuration registers are written directly through the write port
// and must only change while no request is in flight. Indexes beyond the
// register list are ignored. MAX_COUNTER_BITS sets the width of the counter
// flops; counter_bits above it behaves as MAX_COUNTER_BITS.
module prescaled_match_timer import pmt_pkg::*; #(
  parameter int unsigned MAX_COUNTER_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [2:0]          opcode_i,
  input  logic [CntW-1:0]     load_value_i,
  // Result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CntW-1:0]     count_now_o,
  output logic                irq_pending_o,
  output logic                match_level_o,
  output logic                is_running_o
);

  // Configuration registers.
  pmt_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prescale_value   <= PrescaleReset;
      cfg_q.match_value      <= MatchReset;
      cfg_q.counter_bits     <= CntBitsReset;
      cfg_q.reset_on_match   <= 1'b0;
      cfg_q.interrupt_enable <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_PRESCALE:  cfg_q.prescale_value   <= cfg_data_i[PscW-1:0];
        REG_MATCH:     cfg_q.match_value      <= cfg_data_i[CntW-1:0];
        REG_CNT_BITS:  cfg_q.counter_bits     <= cfg_data_i[BitsW-1:0];
        REG_RST_MATCH: cfg_q.reset_on_match   <= cfg_data_i[0];
        REG_IRQ_EN:    cfg_q.interrupt_enable <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Handshake control. A request moves out of the input register when the
  // result slot is empty or its current result is being taken.
  logic s1_valid_q, s1_valid_d;
  logic out_valid_q, out_valid_d;
  logic advance;
  logic accept;

  assign advance     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o  = s1_valid_q && !advance;
  assign accept      = in_valid_i && !in_stall_o;
  assign s1_valid_d  = accept || (s1_valid_q && !advance);
  assign out_valid_d = advance || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Input register payload.
  logic [2:0]      s1_op_q;
  logic [CntW-1:0] s1_load_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= opcode_i;
      s1_load_q <= load_value_i;
    end
  end

  // Timer state. The counter flops are only as wide as the largest active
  // width; the step logic masks everything above it to zero anyway.
  logic [MAX_COUNTER_BITS-1:0] main_count_q;
  logic [PscW-1:0]             prescale_q;
  logic                        enabled_q;
  logic                        flag_q;
  logic                        toggle_q;
  pmt_state_t                  state_cur;
  pmt_state_t                  state_d;

  always_comb begin
    state_cur.main_count     = CntW'(main_count_q);
    state_cur.prescale_count = prescale_q;
    state_cur.enabled        = enabled_q;
    state_cur.flag_pending   = flag_q;
    state_cur.toggle_out     = toggle_q;
  end

  pmt_step #(
    .MaxCounterBits(MAX_COUNTER_BITS)
  ) u_step (
    .cfg_i       (cfg_q),
    .state_i     (state_cur),
    .op_i        (opcode_e'(s1_op_q)),
    .load_value_i(s1_load_q),
    .state_o     (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_count_q <= '0;
      prescale_q   <= '0;
      enabled_q    <= 1'b0;
      flag_q       <= 1'b0;
      toggle_q     <= 1'b0;
    end else if (advance) begin
      main_count_q <= state_d.main_count[MAX_COUNTER_BITS-1:0];
      prescale_q   <= state_d.prescale_count;
      enabled_q    <= state_d.enabled;
      flag_q       <= state_d.flag_pending;
      toggle_q     <= state_d.toggle_out;
    end
  end

  // The state only moves when a new result is loaded, so it is the result.
  assign out_valid_o   = out_valid_q;
  assign count_now_o   = CntW'(main_count_q);
  assign irq_pending_o = flag_q;
  assign match_level_o = toggle_q;
  assign is_running_o  = enabled_q;

  // The input side only stalls when both the input register and a blocked
  // result are occupied.
  `PMT_ASSERT_NOW(a_stall_only_when_full, in_stall_o,
    out_valid_q && out_stall_i && s1_valid_q, "input stalled without a blocked result")
  // A start always leaves the timer running with flag and match output cleared.
  `PMT_ASSERT_NEXT(a_start_clears, advance && (s1_op_q == OP_START),
    enabled_q && !flag_q && !toggle_q, "start did not clear flag and match output")
  // A tick while stopped leaves both counters untouched.
  `PMT_ASSERT_NEXT(a_stopped_tick_holds, advance && (s1_op_q == OP_TICK) && !enabled_q,
    $stable(main_count_q) && $stable(prescale_q), "stopped tick changed a count")
  // State never moves while a result is held back.
  `PMT_ASSERT_NEXT(a_state_holds_on_stall, out_valid_q && out_stall_i,
    $stable(main_count_q) && $stable(flag_q) && $stable(toggle_q),
    "state changed under a stalled result")

endmodule

`default_nettype wire
